[hdl/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants of the matrix sweep engine
// Command and result item layouts, action codes and default sizes.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int DEF_MAX_DIM = 16;

    // Quotient bits produced by the serial divider; larger quotients saturate.
    localparam int QBITS = 35;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_SWEEP = 2'd2;

    localparam logic CFG_SIZE      = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic               singular;
        logic               saturated;
    } t_result;

endpackage

[hdl/matrix_sweep_engine.sv]
// ----------------------------------------------------------------------------
// matrix_sweep_engine: sweep operator on a symmetric Q16.16 matrix
// Writes, reads and sweeps a matrix held in a synchronous RAM.
// ----------------------------------------------------------------------------
// A command item is taken when i_start is high while o_busy is low, and its
// single result item appears on o_result for one cycle with o_done high; the
// receiver cannot stall, so it must take the result in that cycle. A write is
// done from idle, a read once RAM data is registered. A sweep over an active
// dimension n runs the pivot read, a pass copying the pivot column into a small
// column buffer, and then, for each of the n^2 entries, a read-modify-write
// around a 32x32 multiply and a bit-serial divider that produces 35 quotient
// bits, one per cycle. The divider sets the sweep time. A sweep with a singular
// pivot ends at the pivot read, one outside the active size at once. The user
// must write configuration through i_cfg_we only while the block is idle; the
// block itself does not enforce this. Entries must be written before they are read or swept.
// ----------------------------------------------------------------------------
module matrix_sweep_engine #(
    parameter int MAX_DIM = mse_pkg::DEF_MAX_DIM
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  mse_pkg::t_cmd   i_cmd,
    output logic            o_done,
    output mse_pkg::t_result o_result,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [30:0]     i_cfg_data
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int NW = $clog2(MAX_DIM + 1);
    localparam int QB = mse_pkg::QBITS;
    localparam int DW = 32 + QB;
    localparam int CW = $clog2(QB);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_PRD  = 4'd2;
    localparam logic [3:0] S_CRD  = 4'd3;
    localparam logic [3:0] S_CWR  = 4'd4;
    localparam logic [3:0] S_RDA  = 4'd5;
    localparam logic [3:0] S_RDB  = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_ABS  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0]         r_state;
    logic [4:0]         r_size;
    logic [30:0]        r_thr;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_j;
    logic [IW-1:0]      r_k;
    logic [31:0]        r_den;
    logic signed [31:0] r_cik;
    logic signed [31:0] r_xij;
    logic signed [63:0] r_num;
    logic               r_sub;
    logic               r_neg;
    logic               r_ovf;
    logic [DW-1:0]      r_rem;
    logic [DW-1:0]      r_dsh;
    logic [QB-1:0]      r_quo;
    logic [CW-1:0]      r_cnt;
    logic               r_sat;
    logic               r_done;
    mse_pkg::t_result   r_result;

    logic              accept;
    logic [NW-1:0]     n_act;
    logic              row_ok;
    logic              col_ok;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [31:0]       mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [31:0]       mem_rdata;
    logic              cb_we;
    logic [IW-1:0]     cb_raddr;
    logic [31:0]       cb_rdata;
    logic              last_i;
    logic              last_j;
    logic signed [31:0] piv;
    logic              piv_sing;
    logic [63:0]       mag;
    logic              rnd;
    logic [QB:0]       qmag;
    logic signed [QB+2:0] tval;
    logic signed [QB+2:0] fval;
    logic              fsat;
    logic signed [31:0] fres;

    function automatic logic [AW-1:0] ent_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        ent_addr = AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
    endfunction

    assign accept = i_start && (r_state == S_IDLE);
    assign n_act  = (32'(r_size) > MAX_DIM) ? NW'(MAX_DIM) : NW'(r_size);
    assign row_ok = 32'(i_cmd.row) < MAX_DIM;
    assign col_ok = 32'(i_cmd.col) < MAX_DIM;
    assign last_i = (32'(r_i) + 1) == 32'(n_act);
    assign last_j = (32'(r_j) + 1) == 32'(n_act);

    // The pivot is singular when not positive or below the threshold.
    assign piv      = mem_rdata;
    assign piv_sing = piv[31] || (piv == 32'sd0) || (unsigned'(piv) < {1'b0, r_thr});

    assign mag = r_num[63] ? 64'(-r_num) : 64'(r_num);

    // Round to nearest, ties away from zero, apply the sign, and subtract where r_sub is set.
    assign rnd  = {r_rem[31:0], 1'b0} >= {1'b0, r_den};
    assign qmag = r_ovf ? (QB+1)'(1) << QB : {1'b0, r_quo} + (QB+1)'(rnd);
    assign tval = r_neg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    assign fval = r_sub ? (QB+3)'(r_xij) - tval : tval;
    assign fsat = (fval > (QB+3)'(32'sh7fffffff)) || (fval < -(QB+3)'(33'sh080000000));
    assign fres = (fval > (QB+3)'(32'sh7fffffff)) ? 32'sh7fffffff :
                  (fval < -(QB+3)'(33'sh080000000)) ? 32'sh80000000 : 32'(fval);

    // Matrix RAM and column buffer port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ent_addr(r_i, r_j);
        mem_wdata = fres;
        mem_raddr = ent_addr(r_i, r_j);
        cb_we     = 1'b0;
        cb_raddr  = r_j;
        unique case (r_state)
            S_IDLE: begin
                mem_waddr = ent_addr(IW'(i_cmd.row), IW'(i_cmd.col));
                mem_wdata = i_cmd.value;
                mem_we    = accept && (i_cmd.action == mse_pkg::ACT_WRITE) && row_ok && col_ok;
                if (i_cmd.action == mse_pkg::ACT_SWEEP) begin
                    mem_raddr = ent_addr(IW'(i_cmd.row), IW'(i_cmd.row));
                end else begin
                    mem_raddr = ent_addr(IW'(i_cmd.row), IW'(i_cmd.col));
                end
            end
            S_CRD: begin
                mem_raddr = ent_addr(r_i, r_k);
            end
            S_CWR: begin
                cb_we = 1'b1;
            end
            S_RDA: begin
                cb_raddr = r_i;
            end
            S_FIN: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= 5'd16;
            r_thr   <= 31'd1;
            r_done  <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == mse_pkg::CFG_SIZE) begin
                    r_size <= i_cfg_data[4:0];
                end else begin
                    r_thr <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_result <= '0;
                        r_sat    <= 1'b0;
                        r_k      <= IW'(i_cmd.row);
                        r_i      <= '0;
                        r_j      <= '0;
                        if (i_cmd.action == mse_pkg::ACT_READ && row_ok && col_ok) begin
                            r_state <= S_RD;
                        end else if (i_cmd.action == mse_pkg::ACT_SWEEP &&
                                     32'(i_cmd.row) < 32'(n_act)) begin
                            r_state <= S_PRD;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                S_RD: begin
                    r_result.read_data <= mem_rdata;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_PRD: begin
                    r_den <= mem_rdata;
                    if (piv_sing) begin
                        r_result.singular <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CRD;
                    end
                end
                S_CRD: begin
                    r_state <= S_CWR;
                end
                S_CWR: begin
                    if (last_i) begin
                        r_i     <= '0;
                        r_state <= S_RDA;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_cik   <= cb_rdata;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // cb_rdata holds the column value of j, mem_rdata the old entry.
                    r_xij <= mem_rdata;
                    r_sub <= 1'b0;
                    if (r_i == r_k && r_j == r_k) begin
                        r_num <= -64'sh100000000;
                    end else if (r_i == r_k) begin
                        r_num <= {{16{cb_rdata[31]}}, cb_rdata, 16'h0000};
                    end else if (r_j == r_k) begin
                        r_num <= {{16{r_cik[31]}}, r_cik, 16'h0000};
                    end else begin
                        r_num <= r_cik * $signed(cb_rdata);
                        r_sub <= 1'b1;
                    end
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_neg   <= r_num[63];
                    r_ovf   <= DW'(mag) >= {r_den, QB'(0)};
                    r_rem   <= DW'(mag);
                    r_dsh   <= {1'b0, r_den, (QB-1)'(0)};
                    r_quo   <= '0;
                    r_cnt   <= CW'(QB - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_quo <= {r_quo[QB-2:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[QB-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FIN: begin
                    r_sat <= r_sat || fsat;
                    if (last_j) begin
                        r_j <= '0;
                        if (last_i) begin
                            r_result.saturated <= r_sat || fsat;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RDA;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RDA;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    mse_ram #(
        .WIDTH(32),
        .DEPTH(MAX_DIM * MAX_DIM)
    ) u_matrix (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Copy of the pivot column taken before the matrix is overwritten.
    mse_ram #(
        .WIDTH(32),
        .DEPTH(MAX_DIM)
    ) u_column (
        .i_clk  (i_clk),
        .i_we   (cb_we),
        .i_waddr(r_i),
        .i_wdata(mem_rdata),
        .i_raddr(cb_raddr),
        .o_rdata(cb_rdata)
    );

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[hdl/mse_ram.sv]
// ----------------------------------------------------------------------------
// mse_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mse_checker.sv]
// ----------------------------------------------------------------------------
// mse_checker: port-level checks for the matrix sweep engine
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module mse_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input logic             o_done,
    input mse_pkg::t_result o_result
);

    // An accepted item either finishes next cycle or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_done || o_busy))
        else $error("accepted item neither finished nor held busy");

    // No result appears after an idle cycle without a start.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !i_start) |=> !o_done)
        else $error("result item without an accepted command");

    // A singular sweep reports nothing else.
    a_singular_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.singular) |-> (o_result.read_data == 0 && !o_result.saturated))
        else $error("singular result carries other fields");

    // Read data and sweep flags never appear together.
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.read_data != 0) |-> (!o_result.singular && !o_result.saturated))
        else $error("read result carries sweep flags");

endmodule

bind matrix_sweep_engine mse_checker u_mse_checker (.*);

[sim/mse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_scoreboard: result predictor and comparator for the matrix sweep engine
// Watches the command, result and configuration ports. It keeps its own copy
// of the matrix and registers, predicts each result item and compares it.
// ----------------------------------------------------------------------------
module mse_scoreboard (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  mse_pkg::t_cmd    i_cmd,
    input  logic             i_done,
    input  mse_pkg::t_result i_result,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [30:0]      i_cfg_data,
    output int               o_errors,
    output int               o_pending
);

    logic signed [31:0] mat [16][16];
    logic signed [31:0] snap [16][16];
    logic [4:0]         size_reg;
    logic [30:0]        thresh_reg;
    mse_pkg::t_result   expected_q [$];

    // Quotient rounded to nearest, ties away from zero.
    function automatic longint div_round(longint num, longint unsigned den);
        longint unsigned mag, q, r;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = mag / den;
        r = mag % den;
        if (r >= den - r) q++;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] clip32(longint v, ref logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic mse_pkg::t_result sweep_outcome(mse_pkg::t_cmd c);
        mse_pkg::t_result res;
        int n, k;
        longint piv, t;
        logic flag;
        logic signed [31:0] cv;
        res = '0;
        flag = 1'b0;
        case (c.action)
            mse_pkg::ACT_WRITE: mat[c.row][c.col] = c.value;
            mse_pkg::ACT_READ:  res.read_data = mat[c.row][c.col];
            mse_pkg::ACT_SWEEP: begin
                n = (size_reg > 16) ? 16 : size_reg;
                k = c.row;
                if (k < n) begin
                    piv = mat[k][k];
                    if (piv <= 0 || piv < longint'(thresh_reg)) begin
                        res.singular = 1'b1;
                    end else begin
                        snap = mat;
                        mat[k][k] = clip32(div_round(-64'sd4294967296, piv), flag);
                        for (int i = 0; i < n; i++) begin
                            if (i != k) begin
                                cv = clip32(div_round(longint'(snap[i][k]) * 65536, piv),
                                            flag);
                                mat[i][k] = cv;
                                mat[k][i] = cv;
                            end
                        end
                        for (int i = 0; i < n; i++) begin
                            for (int j = 0; j < n; j++) begin
                                if (i != k && j != k) begin
                                    t = div_round(longint'(snap[i][k]) *
                                                  longint'(snap[j][k]), piv);
                                    mat[i][j] = clip32(longint'(snap[i][j]) - t, flag);
                                end
                            end
                        end
                        res.saturated = flag;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        mse_pkg::t_result want;
        if (!i_rst_n) begin
            size_reg   <= 5'd16;
            thresh_reg <= 31'd1;
            expected_q.delete();
            o_errors   <= 0;
            for (int i = 0; i < 16; i++)
                for (int j = 0; j < 16; j++)
                    mat[i][j] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mse_pkg::CFG_SIZE) size_reg <= i_cfg_data[4:0];
                else                                   thresh_reg <= i_cfg_data;
            end
            if (i_start && !i_busy)
                expected_q.push_back(sweep_outcome(i_cmd));
            if (i_done) begin
                if (expected_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("ERROR: result item with none expected: %h", i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want !== i_result) begin
                        if (o_errors < 10)
                            $display("ERROR: exp data %h sing %b sat %b, got %h %b %b",
                                     want.read_data, want.singular, want.saturated,
                                     i_result.read_data, i_result.singular,
                                     i_result.saturated);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/matrix_sweep_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_sweep_engine_tb: stimulus and verdict for the matrix sweep engine
// Fills the whole matrix, runs directed corner items, then random phases of
// writes, reads and sweeps under several size and threshold settings.
// ----------------------------------------------------------------------------
module matrix_sweep_engine_tb;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    mse_pkg::t_cmd    i_cmd;
    logic             o_done;
    mse_pkg::t_result o_result;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [30:0]      i_cfg_data;
    int               errors;
    int               pending;
    int               burst_left;
    logic [4:0]       cur_size;
    logic [30:0]      cur_thresh;

    matrix_sweep_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cmd(i_cmd), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    mse_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_cmd(i_cmd), .i_done(o_done), .i_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The sender works in bursts. Between bursts it drops start for a random
    // gap, which may be zero so that back-to-back items also occur.
    task automatic send_item(mse_pkg::t_cmd c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                i_start <= 1'b0;
                i_cmd   <= mse_pkg::t_cmd'(42'({$urandom, $urandom}));
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        // The item is taken at the first edge where busy is sampled low.
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    function automatic mse_pkg::t_cmd make_cmd(logic [1:0] act, int r, int c,
                                               logic [31:0] v);
        mse_pkg::t_cmd m;
        m.action = act;
        m.row    = r[3:0];
        m.col    = c[3:0];
        m.value  = v;
        return m;
    endfunction

    // Value mix: small numbers keep sweeps meaningful, the rest hit the
    // extremes and full-range values that drive saturation.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h80000) - 32'h40000;
        endcase
    endfunction

    // Registers are only written once every expected result has arrived.
    task automatic set_config(logic [4:0] sz, logic [30:0] th);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mse_pkg::CFG_SIZE;
        i_cfg_data  <= {26'd0, sz};
        @(posedge i_clk);
        i_cfg_index <= mse_pkg::CFG_THRESHOLD;
        i_cfg_data  <= th;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_size   = sz;
        cur_thresh = th;
    endtask

    initial begin
        int n, k, done_items, lim;
        logic [31:0] pv;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_cmd       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= mse_pkg::CFG_SIZE;
        i_cfg_data  <= '0;
        burst_left  = 0;
        cur_size    = 5'd16;
        cur_thresh  = 31'd1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every entry is written first, so no later read or sweep can touch
        // an entry that was never written.
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                send_item(make_cmd(mse_pkg::ACT_WRITE, r, c, pick_value()));

        // Directed corners on a 2x2 active matrix.
        set_config(5'd2, 31'd1);
        send_item(make_cmd(mse_pkg::ACT_WRITE, 0, 0, 32'd1));
        send_item(make_cmd(mse_pkg::ACT_WRITE, 1, 0, 32'h80000000));
        send_item(make_cmd(mse_pkg::ACT_WRITE, 0, 1, 32'h80000000));
        send_item(make_cmd(mse_pkg::ACT_WRITE, 1, 1, 32'h7fffffff));
        send_item(make_cmd(mse_pkg::ACT_READ, 1, 0, 0));
        send_item(make_cmd(mse_pkg::ACT_READ, 1, 1, 0));
        // A tiny pivot makes -1/a overflow, so the sweep saturates.
        send_item(make_cmd(mse_pkg::ACT_SWEEP, 0, 0, 0));
        send_item(make_cmd(mse_pkg::ACT_READ, 0, 0, 0));
        send_item(make_cmd(mse_pkg::ACT_READ, 1, 1, 0));
        // Pivot outside the active size is ignored.
        send_item(make_cmd(mse_pkg::ACT_SWEEP, 15, 7, 32'hffffffff));
        // The unused action code does nothing.
        send_item(make_cmd(2'd3, 15, 15, 32'hffffffff));
        // Zero and negative pivots are always singular.
        send_item(make_cmd(mse_pkg::ACT_WRITE, 0, 0, 32'd0));
        send_item(make_cmd(mse_pkg::ACT_SWEEP, 0, 0, 0));
        send_item(make_cmd(mse_pkg::ACT_WRITE, 0, 0, 32'hfffffffb));
        send_item(make_cmd(mse_pkg::ACT_SWEEP, 0, 0, 0));
        // Entries outside the active size are still read and written.
        send_item(make_cmd(mse_pkg::ACT_WRITE, 15, 15, 32'h00012345));
        send_item(make_cmd(mse_pkg::ACT_READ, 15, 15, 0));
        // A well-behaved pivot of 2.0.
        send_item(make_cmd(mse_pkg::ACT_WRITE, 1, 1, 32'h00020000));
        send_item(make_cmd(mse_pkg::ACT_WRITE, 0, 1, 32'h00010000));
        send_item(make_cmd(mse_pkg::ACT_WRITE, 1, 0, 32'hffff0000));
        send_item(make_cmd(mse_pkg::ACT_SWEEP, 1, 0, 0));
        send_item(make_cmd(mse_pkg::ACT_READ, 0, 0, 0));
        // The swept pivot, now -0.5, is below the threshold and so singular.
        set_config(5'd2, 31'h00030000);
        send_item(make_cmd(mse_pkg::ACT_SWEEP, 1, 0, 0));

        // Random phases. Most phases use small sizes to keep sweeps short.
        done_items = 0;
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:       set_config(5'd0, 31'd0);
                1:       set_config(5'd16, 31'd1);
                2:       set_config(5'd31, 31'h7fffffff);
                3:       set_config(5'd17, 31'd0);
                4:       set_config(5'd1, 31'd1);
                default: set_config(5'($urandom_range(1, 6)),
                                    31'($urandom_range(0, 32'h20000)));
            endcase
            n = (cur_size > 16) ? 16 : cur_size;
            lim = done_items + 80;
            while (done_items < lim) begin
                if ($urandom_range(0, 9) < 5 && n > 0 &&
                    (n <= 6 || $urandom_range(0, 9) == 0)) begin
                    // Pivot write, up to two column writes, then the sweep.
                    k = $urandom_range(0, n - 1);
                    if ($urandom_range(0, 3) == 0) pv = pick_value();
                    else pv = cur_thresh + $urandom_range(0, 32'h40000);
                    send_item(make_cmd(mse_pkg::ACT_WRITE, k, k, pv));
                    repeat ($urandom_range(0, 2))
                        send_item(make_cmd(mse_pkg::ACT_WRITE, $urandom_range(0, n - 1),
                                           k, pick_value()));
                    send_item(make_cmd(mse_pkg::ACT_SWEEP, k, $urandom_range(0, 15),
                                       $urandom));
                    done_items += 3;
                end else begin
                    case ($urandom_range(0, 9))
                        0:          send_item(make_cmd(2'd3, $urandom_range(0, 15),
                                               $urandom_range(0, 15), $urandom));
                        1, 2, 3, 4: send_item(make_cmd(mse_pkg::ACT_READ,
                                               $urandom_range(0, 15),
                                               $urandom_range(0, 15), $urandom));
                        5:          if (n <= 6)
                                        send_item(make_cmd(mse_pkg::ACT_SWEEP,
                                                  $urandom_range(0, 15),
                                                  $urandom_range(0, 15), $urandom));
                        default:    send_item(make_cmd(mse_pkg::ACT_WRITE,
                                               $urandom_range(0, 15),
                                               $urandom_range(0, 15), pick_value()));
                    endcase
                    done_items++;
                end
            end
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hdl/mse_pkg.sv
hdl/mse_ram.sv
hdl/matrix_sweep_engine.sv
hdl/mse_checker.sv
sim/mse_checker.sv
sim/matrix_sweep_engine_tb.sv
